>>> rtl/otsa_pkg.sv
`default_nettype none
package otsa_pkg;

  localparam int SLOTS = 64;
  localparam int AW    = 6;
  localparam int CW    = 7;
  localparam int OW    = 31;

  localparam logic [2:0] FN_ALLOC_FIRST = 3'd0;
  localparam logic [2:0] FN_ALLOC_AT    = 3'd1;
  localparam logic [2:0] FN_FREE_SLOT   = 3'd2;
  localparam logic [2:0] FN_FREE_OWNER  = 3'd3;
  localparam logic [2:0] FN_QUERY       = 3'd4;
  localparam logic [2:0] FN_GROUP       = 3'd5;

  typedef logic [CW-1:0] cnt_t;
  typedef logic [OW-1:0] owner_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    owner_t        data;
  } tbl_wr_t;

endpackage
`default_nettype wire

>>> rtl/otsa_if.sv
`default_nettype none
interface otsa_req_if import otsa_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] func;
  cnt_t       slot;
  owner_t     owner;
  cnt_t       group_count;
  logic       group_first;

  modport source (output valid, func, slot, owner, group_count, group_first, input ready);
  modport sink (input valid, func, slot, owner, group_count, group_first, output ready);
endinterface

interface otsa_rsp_if import otsa_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   status;
  cnt_t   slot_out;
  owner_t owner_out;
  cnt_t   occupied_count;
  cnt_t   free_count;
  cnt_t   group_placed;

  modport source (output valid, status, slot_out, owner_out, occupied_count, free_count,
                  group_placed, input ready);
  modport sink (input valid, status, slot_out, owner_out, occupied_count, free_count,
                group_placed, output ready);
endinterface

interface otsa_cfg_if import otsa_pkg::*; ();
  logic valid;
  logic ready;
  cnt_t capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface
`default_nettype wire

>>> rtl/owner_tagged_slot_allocator_unit.sv
// Owner-tagged slot allocator: a table of up to 64 slots, each free or held by
// a nonzero 31-bit owner id.
// Channels (valid/ready, a word moves when both are high):
//   req - one operation per word: func, slot, owner, group_count, group_first.
//   rsp - one result word per request: status, slot_out, owner_out,
//         occupied_count, free_count, group_placed.
//   cfg - capacity write; taken only while the unit is idle. It empties
//         the table and closes any open group.
// Flow: a request is taken only when the unit is idle. Requests refused up
// front go from the start state straight to the final state; slot-addressed
// operations (alloc at, free slot, query) pass through the check state. A new
// request is taken only after the last result has moved to the output register.
// First-free, free-by-owner and group allocation scan the table one entry per
// cycle through the single read port of the owner memory, up to the first hit
// or the last slot within capacity.
// The result sits in an output register; the next request can be taken while
// it waits. If a second result finishes before the first is taken, the unit
// holds in its final state and takes nothing new until rsp drains.
// Reset: capacity 0 (every request refused), table empty, no open group.
`default_nettype none
module owner_tagged_slot_allocator_unit import otsa_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  otsa_req_if.sink   req,
  otsa_rsp_if.source rsp,
  otsa_cfg_if.sink   cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state;
  cnt_t       capacity;
  cnt_t       occupied;
  logic       group_accepted;
  cnt_t       group_done;
  cnt_t       group_size;

  logic [2:0] f_fn;
  cnt_t       f_slot;
  owner_t     f_owner;
  cnt_t       f_gcount;
  logic       f_gfirst;

  cnt_t   idx;
  cnt_t   chk;
  logic   chk_v;
  logic   res_ok;
  cnt_t   res_slot;
  owner_t res_owner;

  logic   rsp_valid;
  logic   rsp_load;

  cnt_t          cap_eff;
  cnt_t          freec;
  cnt_t          slot_m1;
  logic          slot_ok;
  logic          scan_hit;
  logic          scan_end;
  logic          chk_ok;
  logic          cfg_fire;
  logic          acc_n;
  cnt_t          size_n;
  cnt_t          done_n;
  tbl_wr_t       wr;
  logic [AW-1:0] rd_addr;
  owner_t        rd_data;

  otsa_table u_table (
    .clk     (clk),
    .rst     (rst),
    .clr     (cfg_fire),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cap_eff  = (capacity > CW'(SLOTS)) ? CW'(SLOTS) : capacity;
  assign freec    = cap_eff - occupied;
  assign slot_m1  = f_slot - CW'(1);
  assign slot_ok  = (cap_eff != '0) && (f_slot != '0) && (f_slot <= cap_eff);
  assign cfg_fire = cfg.valid && cfg.ready;
  assign rsp_load = (state == ST_FIN) && (!rsp_valid || rsp.ready);

  assign cfg.ready = (state == ST_IDLE);
  assign req.ready = (state == ST_IDLE) && !cfg.valid;
  assign rsp.valid = rsp_valid;

  always_comb begin
    scan_hit = chk_v && ((f_fn == FN_FREE_OWNER) ? (rd_data == f_owner) : (rd_data == '0));
    scan_end = chk_v && (chk == cap_eff - CW'(1));
    case (f_fn)
      FN_ALLOC_AT:  chk_ok = (rd_data == '0);
      FN_FREE_SLOT: chk_ok = (rd_data != '0);
      default:      chk_ok = 1'b1;
    endcase

    // group state as seen by this item after a first-item restart
    if (f_gfirst) begin
      acc_n  = (cap_eff != '0) && (f_owner != '0) && (f_gcount != '0) && (f_gcount <= freec);
      size_n = acc_n ? f_gcount : '0;
      done_n = '0;
    end else begin
      acc_n  = group_accepted;
      size_n = group_size;
      done_n = group_done;
    end

    wr = '0;
    if (state == ST_SCAN && scan_hit) begin
      wr.en   = 1'b1;
      wr.addr = chk[AW-1:0];
      wr.data = (f_fn == FN_FREE_OWNER) ? '0 : f_owner;
    end else if (state == ST_CHK && chk_ok && f_fn != FN_QUERY) begin
      wr.en   = 1'b1;
      wr.addr = slot_m1[AW-1:0];
      wr.data = (f_fn == FN_ALLOC_AT) ? f_owner : '0;
    end

    rd_addr = (state == ST_START) ? slot_m1[AW-1:0] : idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      capacity       <= '0;
      occupied       <= '0;
      group_accepted <= 1'b0;
      group_done     <= '0;
      group_size     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_fire) begin
            capacity       <= cfg.capacity;
            occupied       <= '0;
            group_accepted <= 1'b0;
            group_done     <= '0;
            group_size     <= '0;
          end else if (req.valid) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          idx       <= '0;
          chk_v     <= 1'b0;
          res_ok    <= 1'b0;
          res_slot  <= '0;
          res_owner <= '0;
          case (f_fn)
            FN_ALLOC_FIRST: begin
              state <= (cap_eff != '0 && f_owner != '0 && freec != '0) ? ST_SCAN : ST_FIN;
            end
            FN_ALLOC_AT: begin
              state <= (slot_ok && f_owner != '0) ? ST_CHK : ST_FIN;
            end
            FN_FREE_SLOT, FN_QUERY: begin
              state <= slot_ok ? ST_CHK : ST_FIN;
            end
            FN_FREE_OWNER: begin
              state <= (cap_eff != '0 && f_owner != '0) ? ST_SCAN : ST_FIN;
            end
            FN_GROUP: begin
              group_accepted <= acc_n;
              group_size     <= size_n;
              group_done     <= done_n;
              if (acc_n && f_owner != '0 && freec != '0 && done_n < size_n) begin
                state <= ST_SCAN;
              end else begin
                state <= ST_FIN;
              end
            end
            default: begin
              state <= ST_FIN;
            end
          endcase
        end
        ST_CHK: begin
          if (chk_ok) begin
            case (f_fn)
              FN_ALLOC_AT: begin
                occupied <= occupied + CW'(1);
                res_slot <= f_slot;
              end
              FN_FREE_SLOT: begin
                occupied  <= occupied - CW'(1);
                res_slot  <= f_slot;
                res_owner <= rd_data;
              end
              default: begin
                res_owner <= rd_data;
              end
            endcase
          end
          res_ok <= chk_ok;
          state  <= ST_FIN;
        end
        ST_SCAN: begin
          if (scan_hit) begin
            res_ok   <= 1'b1;
            res_slot <= chk + CW'(1);
            if (f_fn == FN_FREE_OWNER) begin
              res_owner <= f_owner;
              occupied  <= occupied - CW'(1);
            end else begin
              occupied <= occupied + CW'(1);
              if (f_fn == FN_GROUP) begin
                group_done <= group_done + CW'(1);
                if (group_done + CW'(1) >= group_size) begin
                  group_accepted <= 1'b0;
                end
              end
            end
            state <= ST_FIN;
          end else if (scan_end) begin
            state <= ST_FIN;
          end else begin
            chk_v <= (idx < cap_eff);
            chk   <= idx;
            idx   <= idx + CW'(1);
          end
        end
        ST_FIN: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid && req.ready) begin
      f_fn      <= req.func;
      f_slot    <= req.slot;
      f_owner   <= req.owner;
      f_gcount  <= req.group_count;
      f_gfirst  <= req.group_first;
    end
    if (rsp_load) begin
      rsp.status         <= !res_ok;
      rsp.slot_out       <= res_ok ? res_slot : '0;
      rsp.owner_out      <= res_ok ? res_owner : '0;
      rsp.occupied_count <= occupied;
      rsp.free_count     <= cap_eff - occupied;
      rsp.group_placed   <= group_done;
    end
  end

`ifndef ASSERT_OFF
  a_occ_le_cap: assert property (@(posedge clk) disable iff (rst)
    occupied <= cap_eff)
    else $error("occupied count above capacity");

  a_group_open: assert property (@(posedge clk) disable iff (rst)
    group_accepted |-> (group_done < group_size))
    else $error("open group already complete");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && chk_v) |-> (chk < cap_eff))
    else $error("scan beyond capacity");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (occupied == '0 && !group_accepted))
    else $error("capacity write did not clear state");
`endif

endmodule
`default_nettype wire

>>> rtl/otsa_table.sv
`default_nettype none
module otsa_table import otsa_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire tbl_wr_t       wr,
  input  wire logic [AW-1:0] rd_addr,
  output owner_t             rd_data
);

  owner_t           mem [SLOTS];
  logic [SLOTS-1:0] vld;
  owner_t           rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // never-written entries read as free
  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

>>> tb/owner_tagged_slot_allocator_unit_test.sv
import otsa_pkg::*;

typedef struct packed {
  logic [2:0] func;
  cnt_t       slot;
  owner_t     owner;
  cnt_t       group_count;
  logic       group_first;
} req_word_t;

typedef struct packed {
  logic   status;
  cnt_t   slot_out;
  owner_t owner_out;
  cnt_t   occupied_count;
  cnt_t   free_count;
  cnt_t   group_placed;
} rsp_word_t;

class alloc_tracker;
  owner_t    owners[SLOTS];
  int        occupied;
  bit        grp_open;
  int        grp_done;
  int        grp_size;
  int        capacity;
  int        errors;
  rsp_word_t expected_q[$];

  function new();
    capacity = 0;
    errors = 0;
    clear_table();
  endfunction

  function void clear_table();
    foreach (owners[i]) owners[i] = '0;
    occupied = 0;
    grp_open = 1'b0;
    grp_done = 0;
    grp_size = 0;
  endfunction

  function void set_capacity(cnt_t v);
    capacity = int'(v);
    clear_table();
  endfunction

  function int eff_cap();
    return (capacity > SLOTS) ? SLOTS : capacity;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function int lowest_free(int c);
    for (int i = 0; i < c; i++)
      if (owners[i] == '0) return i;
    return -1;
  endfunction

  function void note_request(req_word_t w);
    rsp_word_t r;
    int        c;
    int        freec;
    bit        slot_ok;
    bit        ok;
    int        k;
    int        sout;
    owner_t    oout;
    int        slot_n;
    c = eff_cap();
    freec = c - occupied;
    slot_n = int'(w.slot);
    slot_ok = (c != 0) && (slot_n >= 1) && (slot_n <= c);
    ok = 1'b0;
    sout = 0;
    oout = '0;
    case (w.func)
      FN_ALLOC_FIRST: begin
        if (c != 0 && w.owner != '0 && freec != 0) begin
          k = lowest_free(c);
          if (k >= 0) begin
            owners[k] = w.owner;
            occupied++;
            sout = k + 1;
            ok = 1'b1;
          end
        end
      end
      FN_ALLOC_AT: begin
        if (slot_ok && w.owner != '0 && owners[slot_n-1] == '0) begin
          owners[slot_n-1] = w.owner;
          occupied++;
          sout = slot_n;
          ok = 1'b1;
        end
      end
      FN_FREE_SLOT: begin
        if (slot_ok && owners[slot_n-1] != '0) begin
          oout = owners[slot_n-1];
          owners[slot_n-1] = '0;
          occupied--;
          sout = slot_n;
          ok = 1'b1;
        end
      end
      FN_FREE_OWNER: begin
        if (c != 0 && w.owner != '0) begin
          for (int i = 0; i < c; i++) begin
            if (owners[i] == w.owner) begin
              owners[i] = '0;
              occupied--;
              sout = i + 1;
              oout = w.owner;
              ok = 1'b1;
              break;
            end
          end
        end
      end
      FN_QUERY: begin
        if (slot_ok) begin
          oout = owners[slot_n-1];
          ok = 1'b1;
        end
      end
      FN_GROUP: begin
        if (w.group_first) begin
          grp_open = 1'b0;
          grp_done = 0;
          grp_size = 0;
          if (c != 0 && w.owner != '0 && int'(w.group_count) >= 1 &&
              int'(w.group_count) <= freec) begin
            grp_open = 1'b1;
            grp_size = int'(w.group_count);
          end
        end
        if (grp_open && w.owner != '0 && (c - occupied) != 0 && grp_done < grp_size) begin
          k = lowest_free(c);
          if (k >= 0) begin
            owners[k] = w.owner;
            occupied++;
            grp_done++;
            sout = k + 1;
            ok = 1'b1;
            if (grp_done >= grp_size) grp_open = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (!ok) begin
      sout = 0;
      oout = '0;
    end
    r.status = ~ok;
    r.slot_out = cnt_t'(sout);
    r.owner_out = oout;
    r.occupied_count = cnt_t'(occupied);
    r.free_count = cnt_t'(c - occupied);
    r.group_placed = cnt_t'(grp_done);
    expected_q.push_back(r);
  endfunction

  function void check_result(rsp_word_t got);
    rsp_word_t exp_w;
    bit        bad;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result word: status=%0d slot=%0d owner=%0h",
                 got.status, got.slot_out, got.owner_out);
      return;
    end
    exp_w = expected_q.pop_front();
    bad = (got.status != exp_w.status) || (got.slot_out != exp_w.slot_out) ||
          (got.owner_out != exp_w.owner_out) ||
          (got.occupied_count != exp_w.occupied_count) ||
          (got.free_count != exp_w.free_count) ||
          (got.group_placed != exp_w.group_placed);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch exp: status=%0d slot=%0d owner=%0h occ=%0d free=%0d placed=%0d",
                 exp_w.status, exp_w.slot_out, exp_w.owner_out, exp_w.occupied_count,
                 exp_w.free_count, exp_w.group_placed);
        $display("         got: status=%0d slot=%0d owner=%0h occ=%0d free=%0d placed=%0d",
                 got.status, got.slot_out, got.owner_out, got.occupied_count,
                 got.free_count, got.group_placed);
      end
    end
  endfunction
endclass

module owner_tagged_slot_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 60;

  logic clk = 1'b0;
  logic rst;
  logic rsp_take = 1'b0;
  logic hold_on = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  event hold_go;

  owner_t       pool[6];
  alloc_tracker tracker = new();

  otsa_req_if req();
  otsa_rsp_if rsp();
  otsa_cfg_if cfg();

  owner_tagged_slot_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  assign rsp.ready = rsp_take;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_word_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status = rsp.status;
      got.slot_out = rsp.slot_out;
      got.owner_out = rsp.owner_out;
      got.occupied_count = rsp.occupied_count;
      got.free_count = rsp.free_count;
      got.group_placed = rsp.group_placed;
      tracker.check_result(got);
    end
    rsp_take <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_req(logic [2:0] f, cnt_t s, owner_t o, cnt_t gc, logic gf);
    req_word_t w;
    w.func = f;
    w.slot = s;
    w.owner = o;
    w.group_count = gc;
    w.group_first = gf;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.slot <= s;
    req.owner <= o;
    req.group_count <= gc;
    req.group_first <= gf;
    do @(posedge clk); while (!req.ready);
    tracker.note_request(w);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_capacity(cnt_t v);
    drain();
    cfg.valid <= 1'b1;
    cfg.capacity <= v;
    do @(posedge clk); while (!cfg.ready);
    tracker.set_capacity(v);
    cfg.valid <= 1'b0;
  endtask

  function automatic cnt_t pick_slot(int c);
    if (c > 0 && $urandom_range(99) < 88) return cnt_t'($urandom_range(1, c));
    return cnt_t'($urandom_range(0, 127));
  endfunction

  function automatic owner_t pick_owner();
    int     r;
    owner_t o;
    r = $urandom_range(99);
    o = owner_t'($urandom());
    if (r < 90) return pool[$urandom_range(0, 5)];
    if (r < 94) return '0;
    return o;
  endfunction

  task automatic send_random_op();
    int         c;
    int         freec;
    int         r;
    logic [2:0] f;
    c = tracker.eff_cap();
    freec = c - tracker.occupied;
    r = $urandom_range(99);
    if (freec == 0 && r < 50) f = (r < 25) ? FN_FREE_SLOT : FN_FREE_OWNER;
    else if (r < 22) f = FN_ALLOC_FIRST;
    else if (r < 38) f = FN_ALLOC_AT;
    else if (r < 58) f = FN_FREE_SLOT;
    else if (r < 74) f = FN_FREE_OWNER;
    else f = FN_QUERY;
    send_req(f, pick_slot(c), pick_owner(), cnt_t'($urandom_range(0, 127)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic run_segment(int n);
    int     left;
    int     r;
    int     freec;
    int     gc;
    int     followers;
    owner_t o;
    left = n;
    while (left > 0) begin
      if ($urandom_range(49) == 0) drain();
      r = $urandom_range(99);
      if (r < 4) begin
        send_req(3'($urandom_range(0, 7)), cnt_t'($urandom_range(0, 127)),
                 owner_t'($urandom()), cnt_t'($urandom_range(0, 127)),
                 1'($urandom_range(0, 1)));
        left--;
      end else if (r < 20) begin
        freec = tracker.eff_cap() - tracker.occupied;
        o = pick_owner();
        if ($urandom_range(99) < 80)
          gc = $urandom_range(1, (freec > 0) ? freec : 1);
        else
          gc = ($urandom_range(1) == 0) ? 0 : $urandom_range(freec + 1, 127);
        send_req(FN_GROUP, pick_slot(tracker.eff_cap()), o, cnt_t'(gc), 1'b1);
        left--;
        followers = tracker.grp_open ? gc - 1 : $urandom_range(0, 1);
        if ($urandom_range(9) == 0) followers++;
        for (int j = 0; j < followers; j++) begin
          if ($urandom_range(9) == 0) begin
            send_random_op();
            left--;
          end
          send_req(FN_GROUP, pick_slot(tracker.eff_cap()),
                   ($urandom_range(29) == 0) ? owner_t'(0) : o,
                   cnt_t'($urandom_range(0, 127)), 1'b0);
          left--;
        end
      end else begin
        send_random_op();
        left--;
      end
    end
  endtask

  initial begin
    int seg_cap[SEGMENTS];
    seg_cap = '{1, 64, 6, 127, 3, 10, 0, 64, 4, 20, 2, 8};
    seg_cap[9] = $urandom_range(1, 30);
    pool[0] = 31'd1;
    pool[1] = 31'h7FFFFFFF;
    for (int i = 2; i < 6; i++) pool[i] = owner_t'($urandom()) | 31'd1;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.func <= FN_ALLOC_FIRST;
    req.slot <= '0;
    req.owner <= '0;
    req.group_count <= '0;
    req.group_first <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.capacity <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no table after reset
    send_req(FN_ALLOC_FIRST, 7'd1, 31'd5, 7'd0, 1'b0);
    send_req(FN_QUERY, 7'd1, 31'd0, 7'd0, 1'b0);
    send_req(FN_GROUP, 7'd0, 31'd5, 7'd1, 1'b1);

    write_capacity(7'd2);
    send_req(FN_ALLOC_FIRST, 7'd0, 31'h7FFFFFFF, 7'd0, 1'b0);
    send_req(FN_ALLOC_AT, 7'd2, 31'd1, 7'd0, 1'b0);
    send_req(FN_ALLOC_FIRST, 7'd0, 31'd3, 7'd0, 1'b0);
    send_req(FN_QUERY, 7'd1, 31'd0, 7'd0, 1'b0);
    send_req(FN_QUERY, 7'd0, 31'd0, 7'd0, 1'b0);
    send_req(FN_QUERY, 7'd3, 31'd0, 7'd0, 1'b0);
    send_req(FN_FREE_SLOT, 7'd1, 31'd0, 7'd0, 1'b0);
    send_req(FN_FREE_SLOT, 7'd1, 31'd0, 7'd0, 1'b0);
    send_req(FN_FREE_OWNER, 7'd0, 31'd1, 7'd0, 1'b0);
    send_req(FN_FREE_OWNER, 7'd0, 31'd1, 7'd0, 1'b0);
    send_req(FN_ALLOC_FIRST, 7'd0, 31'd0, 7'd0, 1'b0);
    send_req(3'd6, 7'd1, 31'd1, 7'd1, 1'b1);
    send_req(3'd7, 7'd1, 31'd1, 7'd1, 1'b1);
    send_req(FN_GROUP, 7'd0, 31'd9, 7'd2, 1'b1);
    send_req(FN_GROUP, 7'd0, 31'd9, 7'd0, 1'b0);
    send_req(FN_GROUP, 7'd0, 31'd9, 7'd0, 1'b0);
    send_req(FN_GROUP, 7'd0, 31'd9, 7'd3, 1'b1);
    send_req(FN_GROUP, 7'd0, 31'd9, 7'd0, 1'b1);

    // capacity above the table size saturates
    write_capacity(7'd127);
    send_req(FN_ALLOC_AT, 7'd64, 31'h2A, 7'd0, 1'b0);
    send_req(FN_ALLOC_AT, 7'd127, 31'h2A, 7'd0, 1'b0);
    send_req(FN_GROUP, 7'd0, 31'd7, 7'd64, 1'b1);
    send_req(FN_FREE_SLOT, 7'd64, 31'd0, 7'd0, 1'b0);
    send_req(FN_GROUP, 7'd0, 31'd7, 7'd127, 1'b1);
    send_req(FN_GROUP, 7'd0, 31'd7, 7'd64, 1'b1);
    send_req(FN_GROUP, 7'd0, 31'd7, 7'd0, 1'b0);

    for (int s = 0; s < SEGMENTS; s++) begin
      write_capacity(cnt_t'(seg_cap[s]));
      case (s % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct = 28;
        end
      endcase
      if (s == 0 || s == 8) -> hold_go;
      run_segment(SEG_ITEMS);
    end

    drain();
    repeat (80) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
